>>> rtl/core/vdc_pkg.sv
// shared types and constants for the vertex dedup chain table
package vdc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COMP_N      = 8;
    localparam int COMP_W      = 32;
    localparam int TOL_W       = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;
    localparam logic [CNT_W-1:0] NO_LINK   = CNT_W'(TABLE_DEPTH);
    localparam logic             REG_TOL   = 1'b0;

    typedef logic [COMP_N-1:0][COMP_W-1:0] t_vert;

    typedef enum logic [1:0] {
        OC_PLACED   = 2'd0,
        OC_MATCHED  = 2'd1,
        OC_APPENDED = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_APP,
        ST_APP_CHK,
        ST_LINK
    } t_state;

    typedef struct packed {
        logic     load;
        logic     clr_step;
        logic     rd_occ;
        logic     place;
        logic     advance;
        logic     end_walk;
        logic     app_write;
        logic     link;
        logic     emit;
        t_outcome outcome;
        logic     full;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic slot_valid;
        logic first;
        logic match;
        logic can_step;
        logic full;
    } t_sts;

endpackage

>>> rtl/core/vdc_ram.sv
// generic single write port ram with registered read
module vdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/vdc_ctrl.sv
// sequencer for clearing, chain walk, append and link
module vdc_ctrl
    import vdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: n_state = ST_CHECK;
            ST_CHECK: begin
                priority if (!i_sts.slot_valid && i_sts.first) n_state = ST_IDLE;
                else if (!i_sts.slot_valid) n_state = ST_APP;
                else if (i_sts.match) n_state = ST_IDLE;
                else if (i_sts.can_step) n_state = ST_LOOKUP;
                else n_state = ST_APP;
            end
            ST_APP: begin
                n_state = i_sts.full ? ST_IDLE : ST_APP_CHK;
            end
            ST_APP_CHK: n_state = ST_LINK;
            ST_LINK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.outcome = OC_PLACED;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: o_cmd.load = i_start;
            ST_LOOKUP: ;
            ST_CHECK: begin
                priority if (!i_sts.slot_valid && i_sts.first) begin
                    o_cmd.place   = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.outcome = OC_PLACED;
                end else if (!i_sts.slot_valid) begin
                    o_cmd.end_walk = 1'b1;
                end else if (i_sts.match) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.outcome = OC_MATCHED;
                end else if (i_sts.can_step) begin
                    o_cmd.advance = 1'b1;
                end else begin
                    o_cmd.end_walk = 1'b1;
                end
            end
            ST_APP: begin
                o_cmd.rd_occ = 1'b1;
                if (i_sts.full) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.outcome = OC_APPENDED;
                    o_cmd.full    = 1'b1;
                end
            end
            ST_APP_CHK: begin
                o_cmd.rd_occ    = 1'b1;
                o_cmd.app_write = 1'b1;
            end
            ST_LINK: begin
                o_cmd.link    = 1'b1;
                o_cmd.emit    = 1'b1;
                o_cmd.outcome = OC_APPENDED;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> rtl/core/vdc_dp.sv
// datapath: vertex store, link store, valid map, compare lanes, counters
module vdc_dp
    import vdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [TOL_W-1:0] i_tol,
    input  logic [IDX_W-1:0] i_suggested_index,
    input  t_vert            i_vert,
    output t_sts             o_sts,
    output logic             o_done,
    output logic [IDX_W-1:0] o_vertex_index,
    output logic [1:0]       o_outcome,
    output logic             o_table_full
);

    t_vert            r_vert;
    logic [IDX_W-1:0] r_cur, r_prev, r_tail, r_target, r_visits, r_clr;
    logic             r_first;
    logic [CNT_W-1:0] r_occ;
    logic             r_done, r_full;
    logic [IDX_W-1:0] r_index;
    t_outcome         r_outcome;

    logic [IDX_W-1:0] raddr;
    logic             vld_we, vld_wdata, vld_rdata;
    logic [IDX_W-1:0] vld_waddr;
    logic             cmp_we;
    logic [IDX_W-1:0] cmp_waddr;
    t_vert            cmp_rdata;
    logic             nxt_we;
    logic [IDX_W-1:0] nxt_waddr;
    logic [CNT_W-1:0] nxt_wdata, nxt_rdata;
    logic [COMP_N-1:0] lane_ok;

    assign raddr = i_cmd.rd_occ ? r_occ[IDX_W-1:0] : r_cur;

    // valid map, swept to zero after reset
    assign vld_we    = i_cmd.clr_step | i_cmd.place | i_cmd.app_write;
    assign vld_wdata = !i_cmd.clr_step;
    always_comb begin
        priority if (i_cmd.clr_step) vld_waddr = r_clr;
        else if (i_cmd.place) vld_waddr = r_cur;
        else vld_waddr = r_occ[IDX_W-1:0];
    end

    assign cmp_we    = i_cmd.place | i_cmd.app_write;
    assign cmp_waddr = i_cmd.place ? r_cur : r_occ[IDX_W-1:0];

    assign nxt_we = i_cmd.place | i_cmd.app_write | i_cmd.link;
    always_comb begin
        priority if (i_cmd.link) begin
            nxt_waddr = r_tail;
            nxt_wdata = {1'b0, r_target};
        end else if (i_cmd.place) begin
            nxt_waddr = r_cur;
            nxt_wdata = NO_LINK;
        end else begin
            nxt_waddr = r_occ[IDX_W-1:0];
            nxt_wdata = NO_LINK;
        end
    end

    vdc_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_vld (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (vld_waddr),
        .i_wdata (vld_wdata),
        .i_raddr (raddr),
        .o_rdata (vld_rdata)
    );

    vdc_ram #(.WIDTH(COMP_N*COMP_W), .DEPTH(TABLE_DEPTH)) u_cmp (
        .i_clk   (i_clk),
        .i_we    (cmp_we),
        .i_waddr (cmp_waddr),
        .i_wdata (r_vert),
        .i_raddr (raddr),
        .o_rdata (cmp_rdata)
    );

    vdc_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_nxt (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (raddr),
        .o_rdata (nxt_rdata)
    );

    // eight independent tolerance lanes, exact 33 bit difference
    always_comb begin
        logic signed [COMP_W:0] diff;
        logic        [COMP_W:0] mag;
        for (int i = 0; i < COMP_N; i++) begin
            diff = $signed({cmp_rdata[i][COMP_W-1], cmp_rdata[i]})
                 - $signed({r_vert[i][COMP_W-1], r_vert[i]});
            mag  = diff[COMP_W] ? (COMP_W+1)'(-diff) : diff;
            lane_ok[i] = (mag <= {{(COMP_W+1-TOL_W){1'b0}}, i_tol});
        end
    end

    assign o_sts.clr_last   = (r_clr == '1);
    assign o_sts.slot_valid = vld_rdata;
    assign o_sts.first      = r_first;
    assign o_sts.match      = &lane_ok;
    assign o_sts.can_step   = !nxt_rdata[IDX_W] && (r_visits != '1);
    assign o_sts.full       = r_occ[IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_occ  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.place || (i_cmd.app_write && !vld_rdata)) begin
                r_occ <= r_occ + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vert   <= i_vert;
            r_cur    <= i_suggested_index;
            r_visits <= '0;
            r_first  <= 1'b1;
        end
        if (i_cmd.advance) begin
            r_prev   <= r_cur;
            r_cur    <= nxt_rdata[IDX_W-1:0];
            r_visits <= r_visits + 1'b1;
            r_first  <= 1'b0;
        end
        // an invalid successor leaves the previous slot as tail
        if (i_cmd.end_walk) r_tail <= vld_rdata ? r_cur : r_prev;
        if (i_cmd.app_write) r_target <= r_occ[IDX_W-1:0];
        if (i_cmd.emit) begin
            r_outcome <= i_cmd.outcome;
            r_full    <= i_cmd.full;
            priority if (i_cmd.full) r_index <= '0;
            else if (i_cmd.outcome == OC_APPENDED) r_index <= r_target;
            else r_index <= r_cur;
        end
    end

    assign o_done         = r_done;
    assign o_vertex_index = r_index;
    assign o_outcome      = r_outcome;
    assign o_table_full   = r_full;

`ifndef ASSERT_OFF
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_full) |-> (r_outcome == OC_APPENDED && r_index == '0))
        else $error("full result with wrong fields");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(TABLE_DEPTH))
        else $error("occupied count beyond table");
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_occ != $past(r_occ)) |-> (r_occ == $past(r_occ) + 1'b1))
        else $error("occupied count jumped");
    a_place_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> (!vld_rdata && r_first))
        else $error("placing over a valid slot");
`endif

endmodule

>>> rtl/core/vertex_dedup_chain_table.sv
// top level: configuration register, controller and datapath
//
// channel   | handshake          | payload
// request   | start / busy       | i_suggested_index, i_pos_*, i_nrm_*, i_tex_*
// result    | o_done strobe      | o_vertex_index, o_outcome, o_table_full
// config    | apb psel / penable | paddr, pwdata, prdata (tolerance at 0x0)
//
// after reset a clearing pass sweeps the valid map, busy high
// a request runs lookup then check, each further chain slot repeats that pair,
// and an append adds the app, app check and link states (only app when full)
// every step reads the single read port of the slot memories, one slot a cycle
// the result strobe comes the cycle after the last step; the receiver cannot stall
module vertex_dedup_chain_table
    import vdc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [IDX_W-1:0]         i_suggested_index,
    input  logic signed [COMP_W-1:0] i_pos_x,
    input  logic signed [COMP_W-1:0] i_pos_y,
    input  logic signed [COMP_W-1:0] i_pos_z,
    input  logic signed [COMP_W-1:0] i_nrm_x,
    input  logic signed [COMP_W-1:0] i_nrm_y,
    input  logic signed [COMP_W-1:0] i_nrm_z,
    input  logic signed [COMP_W-1:0] i_tex_u,
    input  logic signed [COMP_W-1:0] i_tex_v,
    output logic                     o_done,
    output logic [IDX_W-1:0]         o_vertex_index,
    output logic [1:0]               o_outcome,
    output logic                     o_table_full,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [TOL_W-1:0] r_tol;
    t_cmd             cmd;
    t_sts             sts;
    t_vert            vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_TOL) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOL) ? {{(32-TOL_W){1'b0}}, r_tol} : 32'd0;

    assign vert = {i_tex_v, i_tex_u, i_nrm_z, i_nrm_y, i_nrm_x, i_pos_z, i_pos_y, i_pos_x};

    vdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    vdc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_tol             (r_tol),
        .i_suggested_index (i_suggested_index),
        .i_vert            (vert),
        .o_sts             (sts),
        .o_done            (o_done),
        .o_vertex_index    (o_vertex_index),
        .o_outcome         (o_outcome),
        .o_table_full      (o_table_full)
    );

endmodule
